>>> sv/assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define VCW_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("vcw assertion failed");

// consequent that must hold in the cycle after the antecedent
`define VCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) \
      else $error("vcw assertion failed");

`else

`define VCW_ASSERT(label, clk, rst, prop)

`define VCW_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/vcw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vcw_pkg;

   // default sizes of the top level parameters
   localparam int COUNTER_BITS_DEF = 32;
   localparam int TIME_BITS_DEF    = 48;

   // fixed field widths
   localparam int VEL_W       = 16;
   localparam int WALK_W      = 16;
   localparam int TS_W        = 48;
   localparam int CNT_OUT_W   = 32;
   localparam int LIMIT_W     = 16;
   localparam int TIMEOUT_W   = 32;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int MAG_W       = VEL_W + 1;

   // divider: three axes through one restoring divider
   localparam int LANES     = 3;
   localparam int LANE_W    = 2;
   localparam int DIV_STEPS = 14;
   localparam int STEP_W    = 4;

   localparam logic [LANE_W-1:0] LANE_TURN = 2'd2;
   localparam logic [LANE_W-1:0] LANE_LAST = 2'd2;
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

   localparam logic [WALK_W-1:0] Q_ONE = 16'd16384;

   // command codes
   localparam logic [1:0] CMD_VELOCITY = 2'd0;
   localparam logic [1:0] CMD_POLL     = 2'd1;
   localparam logic [1:0] CMD_RESET    = 2'd2;

   // reason codes
   localparam logic [1:0] REASON_COMMAND   = 2'd0;
   localparam logic [1:0] REASON_WATCHDOG  = 2'd1;
   localparam logic [1:0] REASON_BAD_FRAME = 2'd2;
   localparam logic [1:0] REASON_NONFINITE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LINEAR  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ANGULAR = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT     = 2'd2;

   // register reset values
   localparam logic [LIMIT_W-1:0]   MAX_LINEAR_RST  = 16'd256;
   localparam logic [LIMIT_W-1:0]   MAX_ANGULAR_RST = 16'd256;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST     = 32'd500000;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic              load;
      logic              prep;
      logic              div_init;
      logic              div_step;
      logic              div_last;
      logic [LANE_W-1:0] lane;
      logic              emit;
   } dp_cmd_type;

   typedef struct packed {
      logic good_cmd;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

>>> sv/velocity_command_watchdog.sv
`timescale 1ns / 1ps
`default_nettype none

// Velocity command watchdog. Every accepted item gives exactly one result. Items are
// handled one at a time: a good velocity command holds off the next item until the
// shared restoring divider has loaded each of the three axes in turn and formed its 14
// quotient bits; a rejected command, a poll, a reset item or an unused code skips the
// divider. The result sits in an output register, so the next item is taken while it
// waits on rsp_stall. The user must see that registers are written through the csr port
// only while the block is idle; the block itself does not enforce this.
module velocity_command_watchdog #(
   parameter int COUNTER_BITS = vcw_pkg::COUNTER_BITS_DEF,
   parameter int TIME_BITS    = vcw_pkg::TIME_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [vcw_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [vcw_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic                              req_frame_supported,
   input  logic                              req_values_finite,
   input  logic signed [vcw_pkg::VEL_W-1:0]  req_vel_x,
   input  logic signed [vcw_pkg::VEL_W-1:0]  req_vel_y,
   input  logic signed [vcw_pkg::VEL_W-1:0]  req_vel_turn,
   input  logic [vcw_pkg::TS_W-1:0]          req_timestamp,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_action_valid,
   output logic signed [vcw_pkg::WALK_W-1:0] rsp_walk_x,
   output logic signed [vcw_pkg::WALK_W-1:0] rsp_walk_y,
   output logic signed [vcw_pkg::WALK_W-1:0] rsp_walk_turn,
   output logic [1:0]                        rsp_reason,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_received,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_bad_frame,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_nonfinite,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_accepted,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_watchdog,
   output logic [vcw_pkg::CNT_OUT_W-1:0]     rsp_count_invalid_stops
);
   import vcw_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   vcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   vcw_dpath #(
      .COUNTER_BITS (COUNTER_BITS),
      .TIME_BITS    (TIME_BITS)
   ) u_dpath (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .req_command             (req_command),
      .req_frame_supported     (req_frame_supported),
      .req_values_finite       (req_values_finite),
      .req_vel_x               (req_vel_x),
      .req_vel_y               (req_vel_y),
      .req_vel_turn            (req_vel_turn),
      .req_timestamp           (req_timestamp),
      .cmd                     (dp_cmd),
      .status                  (dp_status),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_action_valid        (rsp_action_valid),
      .rsp_walk_x              (rsp_walk_x),
      .rsp_walk_y              (rsp_walk_y),
      .rsp_walk_turn           (rsp_walk_turn),
      .rsp_reason              (rsp_reason),
      .rsp_count_received      (rsp_count_received),
      .rsp_count_bad_frame     (rsp_count_bad_frame),
      .rsp_count_nonfinite     (rsp_count_nonfinite),
      .rsp_count_accepted      (rsp_count_accepted),
      .rsp_count_watchdog      (rsp_count_watchdog),
      .rsp_count_invalid_stops (rsp_count_invalid_stops)
   );

endmodule

`default_nettype wire

>>> sv/vcw_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vcw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  vcw_pkg::dp_status_type status,
   output vcw_pkg::dp_cmd_type    cmd
);
   import vcw_pkg::*;

   ctrl_state_type    state_ff, state_in;
   logic [LANE_W-1:0] lane_ff, lane_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last_step;
   logic              last_axis;

   assign last_step = (step_ff == STEP_LAST);
   assign last_axis = cmd.div_last && (lane_ff == LANE_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lane_ff  <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         lane_ff  <= lane_in;
         step_ff  <= step_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = status.good_cmd ? ST_DIV_INIT : ST_EMIT;
         end
         ST_DIV_INIT: begin
            state_in = ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            if (last_step) state_in = (lane_ff == LANE_LAST) ? ST_EMIT : ST_DIV_INIT;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // axis and iteration counters
   always_comb begin
      lane_in = lane_ff;
      step_in = step_ff;
      unique case (state_ff)
         ST_PREP: begin
            lane_in = '0;
            step_in = '0;
         end
         ST_DIV_STEP: begin
            step_in = last_step ? '0 : step_ff + 1'b1;
            if (last_step && lane_ff != LANE_LAST) lane_in = lane_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      cmd.lane  = lane_ff;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // no transfer while reset is held
            req_stall = reset;
            cmd.load  = req_valid && !reset;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            cmd.div_last = last_step;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
         end
      endcase
   end

   `VCW_ASSERT(a_step_in_range, clock, reset, step_ff <= STEP_LAST)
   `VCW_ASSERT_NEXT(a_last_axis_emits, clock, reset, last_axis, state_ff == ST_EMIT)

endmodule

`default_nettype wire

>>> sv/vcw_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module vcw_dpath #(
   parameter int COUNTER_BITS = vcw_pkg::COUNTER_BITS_DEF,
   parameter int TIME_BITS    = vcw_pkg::TIME_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [vcw_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [vcw_pkg::CSR_DATA_W-1:0]         csr_write_data,
   input  logic [1:0]                             req_command,
   input  logic                                   req_frame_supported,
   input  logic                                   req_values_finite,
   input  logic signed [vcw_pkg::VEL_W-1:0]       req_vel_x,
   input  logic signed [vcw_pkg::VEL_W-1:0]       req_vel_y,
   input  logic signed [vcw_pkg::VEL_W-1:0]       req_vel_turn,
   input  logic [vcw_pkg::TS_W-1:0]               req_timestamp,
   input  vcw_pkg::dp_cmd_type                    cmd,
   output vcw_pkg::dp_status_type                 status,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_action_valid,
   output logic signed [vcw_pkg::WALK_W-1:0]      rsp_walk_x,
   output logic signed [vcw_pkg::WALK_W-1:0]      rsp_walk_y,
   output logic signed [vcw_pkg::WALK_W-1:0]      rsp_walk_turn,
   output logic [1:0]                             rsp_reason,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_received,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_bad_frame,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_nonfinite,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_accepted,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_watchdog,
   output logic [vcw_pkg::CNT_OUT_W-1:0]          rsp_count_invalid_stops
);
   import vcw_pkg::*;

   localparam int CmpW   = (TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W;
   localparam int NumCnt = 6;

   localparam int CntReceived     = 0;
   localparam int CntBadFrame     = 1;
   localparam int CntNonfinite    = 2;
   localparam int CntAccepted     = 3;
   localparam int CntWatchdog     = 4;
   localparam int CntInvalidStops = 5;

   // configuration
   logic [LIMIT_W-1:0]   lin_limit_ff, lin_limit_in;
   logic [LIMIT_W-1:0]   ang_limit_ff, ang_limit_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;

   // captured item
   logic [1:0]           command_ff, command_in;
   logic                 frame_ff, frame_in;
   logic                 finite_ff, finite_in;
   logic [VEL_W-1:0]     vel_ff [LANES];
   logic [VEL_W-1:0]     vel_in [LANES];
   logic [TIME_BITS-1:0] now_ff, now_in;

   // per-axis preparation
   logic [MAG_W-1:0]     mag_ff [LANES];
   logic [MAG_W-1:0]     mag_in [LANES];
   logic                 sat_ff [LANES];
   logic                 sat_in [LANES];
   logic                 zero_ff [LANES];
   logic                 zero_in [LANES];
   logic [TIME_BITS-1:0] diff_ff, diff_in;
   logic                 borrow_ff, borrow_in;

   // shared divider
   logic [LIMIT_W-1:0]   rem_ff, rem_in;
   logic [DIV_STEPS-2:0] quo_ff, quo_in;
   logic [DIV_STEPS-1:0] q_ff [LANES];
   logic [DIV_STEPS-1:0] q_in [LANES];
   logic [LIMIT_W-1:0]   lane_limit;
   logic [LIMIT_W:0]     rem2;
   logic [LIMIT_W:0]     rem_sub;
   logic                 rem_ge;
   logic [DIV_STEPS-1:0] q_next;

   // watchdog and gating state
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic                 has_ff, has_in;
   logic                 active_ff, active_in;
   logic                 zs_ff, zs_in;
   logic [COUNTER_BITS-1:0] cnt_ff [NumCnt];
   logic [COUNTER_BITS-1:0] cnt_in [NumCnt];
   logic [NumCnt-1:0]    cnt_inc;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_action_ff, rsp_action_in;
   logic [WALK_W-1:0]    rsp_walk_ff [LANES];
   logic [WALK_W-1:0]    rsp_walk_in [LANES];
   logic [1:0]           rsp_reason_ff, rsp_reason_in;

   // decision terms
   logic                 is_vel, is_poll, is_rst;
   logic                 good, reject, reject_stop, timed_out, fire;
   logic [WALK_W-1:0]    walk_c [LANES];

   assign status.good_cmd = (command_ff == CMD_VELOCITY) && frame_ff && finite_ff;
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      lin_limit_in = lin_limit_ff;
      ang_limit_in = ang_limit_ff;
      timeout_in   = timeout_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_LINEAR:  lin_limit_in = csr_write_data[LIMIT_W-1:0];
            CSR_MAX_ANGULAR: ang_limit_in = csr_write_data[LIMIT_W-1:0];
            CSR_TIMEOUT:     timeout_in   = csr_write_data[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // capture of the item
   always_comb begin
      command_in = command_ff;
      frame_in   = frame_ff;
      finite_in  = finite_ff;
      now_in     = now_ff;
      for (int i = 0; i < LANES; i++) vel_in[i] = vel_ff[i];
      if (cmd.load) begin
         command_in = req_command;
         frame_in   = req_frame_supported;
         finite_in  = req_values_finite;
         now_in     = TIME_BITS'(req_timestamp);
         vel_in[0]  = req_vel_x;
         vel_in[1]  = req_vel_y;
         vel_in[2]  = req_vel_turn;
      end
   end

   // magnitudes, saturation test and elapsed time
   always_comb begin
      diff_in   = diff_ff;
      borrow_in = borrow_ff;
      for (int i = 0; i < LANES; i++) begin
         mag_in[i]  = mag_ff[i];
         sat_in[i]  = sat_ff[i];
         zero_in[i] = zero_ff[i];
      end
      if (cmd.prep) begin
         {borrow_in, diff_in} = {1'b0, now_ff} - {1'b0, last_ff};
         for (int i = 0; i < LANES; i++) begin
            mag_in[i] = vel_ff[i][VEL_W-1] ? (MAG_W'(0) - {vel_ff[i][VEL_W-1], vel_ff[i]})
                                           : {1'b0, vel_ff[i]};
            zero_in[i] = (vel_ff[i] == '0);
         end
         // quotient reaches one exactly when the magnitude reaches the limit
         sat_in[0] = (mag_in[0] >= {1'b0, lin_limit_ff});
         sat_in[1] = (mag_in[1] >= {1'b0, lin_limit_ff});
         sat_in[2] = (mag_in[2] >= {1'b0, ang_limit_ff});
      end
   end

   // restoring divider, one quotient bit a cycle
   assign lane_limit = (cmd.lane == LANE_TURN) ? ang_limit_ff : lin_limit_ff;
   assign rem2       = {rem_ff, 1'b0};
   assign rem_ge     = (rem2 >= {1'b0, lane_limit});
   assign rem_sub    = rem2 - {1'b0, lane_limit};
   assign q_next     = {quo_ff, rem_ge};

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      for (int i = 0; i < LANES; i++) q_in[i] = q_ff[i];
      if (cmd.div_init) begin
         rem_in = mag_ff[cmd.lane][LIMIT_W-1:0];
         quo_in = '0;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? rem_sub[LIMIT_W-1:0] : rem2[LIMIT_W-1:0];
         quo_in = q_next[DIV_STEPS-2:0];
         if (cmd.div_last) q_in[cmd.lane] = q_next;
      end
   end

   // decision
   assign is_vel      = (command_ff == CMD_VELOCITY);
   assign is_poll     = (command_ff == CMD_POLL);
   assign is_rst      = (command_ff == CMD_RESET);
   assign good        = status.good_cmd;
   assign reject      = is_vel && !(frame_ff && finite_ff);
   assign reject_stop = reject && !(!active_ff && zs_ff);
   assign timed_out   = !borrow_ff && (CmpW'(diff_ff) >= CmpW'(timeout_ff));
   assign fire        = is_poll && has_ff && active_ff && !zs_ff && timed_out;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         if (zero_ff[i]) walk_c[i] = '0;
         else if (sat_ff[i]) walk_c[i] = Q_ONE;
         else walk_c[i] = {2'b00, q_ff[i]};
         if (vel_ff[i][VEL_W-1]) walk_c[i] = WALK_W'(0) - walk_c[i];
      end
   end

   assign cnt_inc[CntReceived]     = is_vel;
   assign cnt_inc[CntBadFrame]     = is_vel && !frame_ff;
   assign cnt_inc[CntNonfinite]    = is_vel && frame_ff && !finite_ff;
   assign cnt_inc[CntAccepted]     = good;
   assign cnt_inc[CntWatchdog]     = fire;
   assign cnt_inc[CntInvalidStops] = reject_stop;

   always_comb begin
      last_in   = last_ff;
      has_in    = has_ff;
      active_in = active_ff;
      zs_in     = zs_ff;
      for (int i = 0; i < NumCnt; i++) cnt_in[i] = cnt_ff[i];
      if (cmd.emit) begin
         for (int i = 0; i < NumCnt; i++) begin
            cnt_in[i] = cnt_ff[i] + {{(COUNTER_BITS-1){1'b0}}, cnt_inc[i]};
         end
         if (good) begin
            last_in   = now_ff;
            has_in    = 1'b1;
            active_in = 1'b1;
            zs_in     = 1'b0;
         end
         if (reject_stop || fire) begin
            active_in = 1'b0;
            zs_in     = 1'b1;
         end
         if (is_rst) begin
            has_in    = 1'b0;
            active_in = 1'b0;
            zs_in     = 1'b1;
         end
      end
   end

   // result register, refilled when empty or in the cycle the previous result transfers
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_action_in = rsp_action_ff;
      rsp_reason_in = rsp_reason_ff;
      for (int i = 0; i < LANES; i++) rsp_walk_in[i] = rsp_walk_ff[i];
      if (cmd.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = good || reject_stop || fire;
         for (int i = 0; i < LANES; i++) rsp_walk_in[i] = good ? walk_c[i] : '0;
         if (fire) rsp_reason_in = REASON_WATCHDOG;
         else if (reject_stop) rsp_reason_in = frame_ff ? REASON_NONFINITE : REASON_BAD_FRAME;
         else rsp_reason_in = REASON_COMMAND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lin_limit_ff <= MAX_LINEAR_RST;
         ang_limit_ff <= MAX_ANGULAR_RST;
         timeout_ff   <= TIMEOUT_RST;
         last_ff      <= '0;
         has_ff       <= 1'b0;
         active_ff    <= 1'b0;
         zs_ff        <= 1'b1;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NumCnt; i++) cnt_ff[i] <= '0;
      end else begin
         lin_limit_ff <= lin_limit_in;
         ang_limit_ff <= ang_limit_in;
         timeout_ff   <= timeout_in;
         last_ff      <= last_in;
         has_ff       <= has_in;
         active_ff    <= active_in;
         zs_ff        <= zs_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NumCnt; i++) cnt_ff[i] <= cnt_in[i];
      end
   end

   always_ff @(posedge clock) begin
      command_ff    <= command_in;
      frame_ff      <= frame_in;
      finite_ff     <= finite_in;
      now_ff        <= now_in;
      diff_ff       <= diff_in;
      borrow_ff     <= borrow_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      rsp_action_ff <= rsp_action_in;
      rsp_reason_ff <= rsp_reason_in;
      for (int i = 0; i < LANES; i++) begin
         vel_ff[i]      <= vel_in[i];
         mag_ff[i]      <= mag_in[i];
         sat_ff[i]      <= sat_in[i];
         zero_ff[i]     <= zero_in[i];
         q_ff[i]        <= q_in[i];
         rsp_walk_ff[i] <= rsp_walk_in[i];
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_action_valid        = rsp_action_ff;
   assign rsp_walk_x              = rsp_walk_ff[0];
   assign rsp_walk_y              = rsp_walk_ff[1];
   assign rsp_walk_turn           = rsp_walk_ff[2];
   assign rsp_reason              = rsp_reason_ff;
   assign rsp_count_received      = CNT_OUT_W'(cnt_ff[CntReceived]);
   assign rsp_count_bad_frame     = CNT_OUT_W'(cnt_ff[CntBadFrame]);
   assign rsp_count_nonfinite     = CNT_OUT_W'(cnt_ff[CntNonfinite]);
   assign rsp_count_accepted      = CNT_OUT_W'(cnt_ff[CntAccepted]);
   assign rsp_count_watchdog      = CNT_OUT_W'(cnt_ff[CntWatchdog]);
   assign rsp_count_invalid_stops = CNT_OUT_W'(cnt_ff[CntInvalidStops]);

   `VCW_ASSERT(a_active_vs_zero_sent, clock, reset, active_ff != zs_ff)
   `VCW_ASSERT(a_armed_needs_command, clock, reset, !active_ff || has_ff)
   `VCW_ASSERT(a_stop_drives_zero, clock, reset, (rsp_valid_ff && rsp_reason_ff != REASON_COMMAND) |-> (rsp_walk_ff[0] == '0 && rsp_walk_ff[1] == '0 && rsp_walk_ff[2] == '0))
   `VCW_ASSERT_NEXT(a_emit_loads_result, clock, reset, cmd.emit, rsp_valid_ff)

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import vcw_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int EV_RECEIVED      = 0;
   localparam int EV_BAD_FRAME     = 1;
   localparam int EV_NONFINITE     = 2;
   localparam int EV_ACCEPTED      = 3;
   localparam int EV_WATCHDOG      = 4;
   localparam int EV_INVALID_STOPS = 5;

   typedef struct packed {
      logic [1:0]         command;
      logic               frame_ok;
      logic               finite_ok;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_turn;
      logic [47:0]        stamp;
   } walk_item_type;

   typedef struct packed {
      logic               action;
      logic signed [15:0] walk_x;
      logic signed [15:0] walk_y;
      logic signed [15:0] walk_turn;
      logic [1:0]         reason;
      logic [5:0][31:0]   counts;
   } walk_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_command = '0;
   logic        req_frame_supported = 1'b0;
   logic        req_values_finite = 1'b0;
   logic signed [15:0] req_vel_x = '0;
   logic signed [15:0] req_vel_y = '0;
   logic signed [15:0] req_vel_turn = '0;
   logic [47:0] req_timestamp = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_action_valid;
   logic signed [15:0] rsp_walk_x;
   logic signed [15:0] rsp_walk_y;
   logic signed [15:0] rsp_walk_turn;
   logic [1:0]  rsp_reason;
   logic [31:0] rsp_count_received;
   logic [31:0] rsp_count_bad_frame;
   logic [31:0] rsp_count_nonfinite;
   logic [31:0] rsp_count_accepted;
   logic [31:0] rsp_count_watchdog;
   logic [31:0] rsp_count_invalid_stops;
   logic [5:0][31:0] seen_counts;

   // predictor copy of registers and state
   logic [15:0] lin_limit = MAX_LINEAR_RST;
   logic [15:0] ang_limit = MAX_ANGULAR_RST;
   logic [31:0] timeout_ticks = TIMEOUT_RST;
   logic [47:0] wd_last_stamp = '0;
   logic        wd_has_cmd = 1'b0;
   logic        wd_moving = 1'b0;
   logic        wd_stopped = 1'b1;
   logic [31:0] event_count [6] = '{0, 0, 0, 0, 0, 0};

   walk_result_type expected_walk [$];
   logic [47:0]  stamp_clock = '0;
   logic         source_idling = 1'b0;
   logic         sink_idling = 1'b0;
   int unsigned  hold_off_len = 0;
   int unsigned  error_count = 0;
   int unsigned  cycle_count = 0;
   int unsigned  items_sent = 0;
   int unsigned  results_checked = 0;
   int unsigned  reason_tally [4] = '{0, 0, 0, 0};
   int unsigned  silent_tally = 0;
   string counter_label [6] = '{"count_received", "count_bad_frame", "count_nonfinite",
                                "count_accepted", "count_watchdog", "count_invalid_stops"};

   assign seen_counts = {rsp_count_invalid_stops, rsp_count_watchdog, rsp_count_accepted,
                         rsp_count_nonfinite, rsp_count_bad_frame, rsp_count_received};

   velocity_command_watchdog dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_write_enable        (csr_write_enable),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_command             (req_command),
      .req_frame_supported     (req_frame_supported),
      .req_values_finite       (req_values_finite),
      .req_vel_x               (req_vel_x),
      .req_vel_y               (req_vel_y),
      .req_vel_turn            (req_vel_turn),
      .req_timestamp           (req_timestamp),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_action_valid        (rsp_action_valid),
      .rsp_walk_x              (rsp_walk_x),
      .rsp_walk_y              (rsp_walk_y),
      .rsp_walk_turn           (rsp_walk_turn),
      .rsp_reason              (rsp_reason),
      .rsp_count_received      (rsp_count_received),
      .rsp_count_bad_frame     (rsp_count_bad_frame),
      .rsp_count_nonfinite     (rsp_count_nonfinite),
      .rsp_count_accepted      (rsp_count_accepted),
      .rsp_count_watchdog      (rsp_count_watchdog),
      .rsp_count_invalid_stops (rsp_count_invalid_stops)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_walk.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic report_error(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   // signed Q8.8 over unsigned Q8.8 limit gives Q2.14, saturated at one
   function automatic logic [15:0] scale_axis(input logic [15:0] raw, input logic [15:0] limit);
      logic [16:0] mag;
      logic [30:0] quot;
      mag = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
      if (mag == 17'd0)
         return 16'd0;
      if (limit == 16'd0) begin
         quot = 31'(Q_ONE);
      end else begin
         quot = {mag, 14'd0} / {15'd0, limit};
         if (quot > 31'(Q_ONE))
            quot = 31'(Q_ONE);
      end
      return raw[15] ? -quot[15:0] : quot[15:0];
   endfunction

   function automatic walk_result_type predict_walk(input walk_item_type it);
      walk_result_type r;
      logic halt;
      r = '0;
      halt = 1'b0;
      case (it.command)
         CMD_VELOCITY: begin
            event_count[EV_RECEIVED]++;
            if (!it.frame_ok || !it.finite_ok) begin
               // frame check wins when both are bad
               if (!it.frame_ok) begin
                  event_count[EV_BAD_FRAME]++;
                  r.reason = REASON_BAD_FRAME;
               end else begin
                  event_count[EV_NONFINITE]++;
                  r.reason = REASON_NONFINITE;
               end
               if (wd_moving || !wd_stopped) begin
                  event_count[EV_INVALID_STOPS]++;
                  halt = 1'b1;
               end else begin
                  r.reason = REASON_COMMAND;
               end
            end else begin
               r.walk_x = scale_axis(it.vel_x, lin_limit);
               r.walk_y = scale_axis(it.vel_y, lin_limit);
               r.walk_turn = scale_axis(it.vel_turn, ang_limit);
               wd_last_stamp = it.stamp;
               wd_has_cmd = 1'b1;
               wd_moving = 1'b1;
               wd_stopped = 1'b0;
               event_count[EV_ACCEPTED]++;
               r.action = 1'b1;
               r.reason = REASON_COMMAND;
            end
         end
         CMD_POLL: begin
            if (wd_has_cmd && wd_moving && !wd_stopped && it.stamp >= wd_last_stamp &&
                (it.stamp - wd_last_stamp) >= {16'd0, timeout_ticks}) begin
               event_count[EV_WATCHDOG]++;
               r.reason = REASON_WATCHDOG;
               halt = 1'b1;
            end
         end
         CMD_RESET: begin
            wd_has_cmd = 1'b0;
            wd_moving = 1'b0;
            wd_stopped = 1'b1;
         end
         default: ;
      endcase
      if (halt) begin
         wd_moving = 1'b0;
         wd_stopped = 1'b1;
         r.action = 1'b1;
         r.walk_x = '0;
         r.walk_y = '0;
         r.walk_turn = '0;
      end
      for (int i = 0; i < 6; i++)
         r.counts[i] = event_count[i];
      return r;
   endfunction

   function automatic walk_item_type make_item(input logic [1:0] cmd, input logic frame_ok,
                                               input logic finite_ok, input logic [15:0] vx,
                                               input logic [15:0] vy, input logic [15:0] vt,
                                               input logic [47:0] stamp);
      walk_item_type it;
      it.command = cmd;
      it.frame_ok = frame_ok;
      it.finite_ok = finite_ok;
      it.vel_x = vx;
      it.vel_y = vy;
      it.vel_turn = vt;
      it.stamp = stamp;
      return it;
   endfunction

   function automatic logic [15:0] random_velocity(input logic [15:0] limit);
      int span;
      int v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               3: return 16'h0001;
               default: return 16'hffff;
            endcase
         end
         1, 2, 3: return 16'($urandom);
         default: begin
            // mostly around the limit, so both saturated and unsaturated quotients occur
            span = int'(limit) + int'(limit) / 4 + 1;
            v = int'($urandom_range(0, 2 * span)) - span;
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
         end
      endcase
   endfunction

   function automatic logic [47:0] next_stamp();
      int unsigned pick;
      logic [63:0] wide;
      logic [47:0] span;
      pick = $urandom_range(0, 99);
      span = (timeout_ticks < 32'd3000) ? {16'd0, timeout_ticks >> 1} : 48'd1500;
      if (pick < 3) begin
         wide = {$urandom, $urandom};
         stamp_clock = wide[47:0];
      end else if (pick < 8) begin
         // earlier than the current stamp clock
         return stamp_clock - 48'($urandom_range(1, 50));
      end else if (pick < 30) begin
         stamp_clock = stamp_clock + {16'd0, timeout_ticks} + 48'($urandom_range(0, 3));
      end else begin
         stamp_clock = stamp_clock + 48'($urandom_range(0, int'(span)));
      end
      return stamp_clock;
   endfunction

   function automatic walk_item_type random_item();
      walk_item_type it;
      int unsigned pick;
      int unsigned flaw;
      pick = $urandom_range(0, 99);
      flaw = $urandom_range(0, 99);
      if (pick < 58) it.command = CMD_VELOCITY;
      else if (pick < 90) it.command = CMD_POLL;
      else if (pick < 97) it.command = CMD_RESET;
      else it.command = CMD_UNUSED;
      it.frame_ok = !(flaw < 8);
      it.finite_ok = !(flaw >= 5 && flaw < 15);
      it.vel_x = random_velocity(lin_limit);
      it.vel_y = random_velocity(lin_limit);
      it.vel_turn = random_velocity(ang_limit);
      it.stamp = next_stamp();
      return it;
   endfunction

   task automatic send_item(input walk_item_type it);
      walk_result_type want;
      if (source_idling && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= it.command;
      req_frame_supported <= it.frame_ok;
      req_values_finite <= it.finite_ok;
      req_vel_x <= it.vel_x;
      req_vel_y <= it.vel_y;
      req_vel_turn <= it.vel_turn;
      req_timestamp <= it.stamp;
      do @(posedge clock); while (req_stall !== 1'b0);
      want = predict_walk(it);
      expected_walk.push_back(want);
      items_sent++;
      if (want.action) reason_tally[want.reason]++;
      else silent_tally++;
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      wait (expected_walk.size() == 0);
      @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MAX_LINEAR:  lin_limit = value[15:0];
         CSR_MAX_ANGULAR: ang_limit = value[15:0];
         CSR_TIMEOUT:     timeout_ticks = value;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [15:0] lin, input logic [15:0] ang,
                            input logic [31:0] limit_ticks);
      wait_for_drain();
      // unused upper bits of the limit registers carry noise
      write_register(CSR_MAX_LINEAR, {16'($urandom), lin});
      write_register(CSR_MAX_ANGULAR, {16'($urandom), ang});
      write_register(CSR_TIMEOUT, limit_ticks);
   endtask

   task automatic run_random(input int unsigned count);
      repeat (count) send_item(random_item());
   endtask

   task automatic test_directed_sequence();
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd0));
      send_item(make_item(CMD_VELOCITY, 0, 1, 16'h0100, 0, 0, 48'd10));
      send_item(make_item(CMD_VELOCITY, 1, 0, 16'h0100, 0, 0, 48'd20));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h7fff, 16'h8000, 16'h0000, 48'd1000));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0080, 16'hffff, 16'h0100, 48'd2000));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd1999));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd501999));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd502000));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd900000));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'hff00, 16'h0040, 16'hff80, 48'd1000000));
      send_item(make_item(CMD_VELOCITY, 0, 0, 16'h1234, 16'h4321, 16'h0f0f, 48'd1000001));
      send_item(make_item(CMD_VELOCITY, 1, 0, 16'h1234, 16'h4321, 16'h0f0f, 48'd1000002));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0033, 16'hffcd, 16'h00ff, 48'd1100000));
      send_item(make_item(CMD_VELOCITY, 1, 0, 16'h5555, 16'haaaa, 16'h5555, 48'd1100001));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0001, 16'h0002, 16'h0003, 48'd1200000));
      send_item(make_item(CMD_RESET, 1, 1, 0, 0, 0, 48'd1200001));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd5000000));
      send_item(make_item(CMD_UNUSED, 1, 1, 16'haaaa, 16'h5555, 16'hffff, 48'haaaa_5555_aaaa));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h8001, 16'h7ffe, 16'h8000, 48'hffff_ffff_ffff));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd0));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'hffff_ffff_ffff));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0200, 16'hfe00, 16'h0000, 48'd100));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd500100));
      stamp_clock = 48'd600000;
   endtask

   task automatic test_register_extremes();
      // zero limits and a zero timeout lie outside the normal range
      configure(16'd0, 16'd0, 32'd0);
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0005, 16'hfffb, 16'h0000, 48'd700000));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd700000));
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h8000, 16'h7fff, 16'h0001, 48'd700010));
      configure(16'hffff, 16'hffff, 32'hffff_ffff);
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h7fff, 16'h8000, 16'h4000, 48'd800000));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd800000 + 48'hffff_fffe));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd800000 + 48'hffff_ffff));
      configure(16'd1, 16'd1, 32'd1);
      send_item(make_item(CMD_VELOCITY, 1, 1, 16'h0001, 16'hffff, 16'h0000, 48'd900000));
      send_item(make_item(CMD_POLL, 1, 1, 0, 0, 0, 48'd900001));
      stamp_clock = 48'd1000000;
   endtask

   task automatic test_random_limits();
      configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                32'($urandom_range(50, 5000)));
      run_random(250);
   endtask

   task automatic test_tight_limits();
      configure(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)), 32'd1);
      run_random(200);
   endtask

   task automatic test_long_timeout();
      configure(16'($urandom_range(30000, 65535)), 16'($urandom_range(30000, 65535)),
                {1'b1, 31'($urandom)});
      run_random(150);
   endtask

   task automatic test_backpressure();
      configure(16'($urandom_range(64, 2048)), 16'($urandom_range(64, 2048)),
                32'($urandom_range(100, 1000)));
      // receiver holds off while the sender keeps offering
      hold_off_len = 300;
      run_random(30);
      wait_for_drain();
   endtask

   task automatic test_streaming();
      source_idling = 1'b0;
      sink_idling = 1'b0;
      configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                32'($urandom_range(20, 3000)));
      run_random(250);
   endtask

   // receiver stall pattern
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_len != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_off_len) @(posedge clock);
            hold_off_len = 0;
            rsp_stall <= 1'b0;
         end else if (sink_idling && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      walk_result_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (expected_walk.size() == 0) begin
            report_error("result transfer with nothing expected");
         end else begin
            want = expected_walk.pop_front();
            results_checked++;
            if (rsp_action_valid !== want.action)
               report_error($sformatf("action_valid got %b expected %b",
                                      rsp_action_valid, want.action));
            if (rsp_walk_x !== want.walk_x)
               report_error($sformatf("walk_x got %0d expected %0d", rsp_walk_x, want.walk_x));
            if (rsp_walk_y !== want.walk_y)
               report_error($sformatf("walk_y got %0d expected %0d", rsp_walk_y, want.walk_y));
            if (rsp_walk_turn !== want.walk_turn)
               report_error($sformatf("walk_turn got %0d expected %0d",
                                      rsp_walk_turn, want.walk_turn));
            if (rsp_reason !== want.reason)
               report_error($sformatf("reason got %0d expected %0d", rsp_reason, want.reason));
            for (int i = 0; i < 6; i++)
               if (seen_counts[i] !== want.counts[i])
                  report_error($sformatf("%s got %0d expected %0d", counter_label[i],
                                         seen_counts[i], want.counts[i]));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      source_idling = 1'b1;
      sink_idling = 1'b1;
      test_directed_sequence();
      test_register_extremes();
      test_random_limits();
      test_tight_limits();
      test_long_timeout();
      test_backpressure();
      test_streaming();
      wait_for_drain();
      repeat (64) @(posedge clock);
      $display("run covered %0d transfers in, %0d results checked", items_sent, results_checked);
      $display("drives %0d, watchdog stops %0d, frame stops %0d, non-finite stops %0d, quiet %0d",
               reason_tally[REASON_COMMAND], reason_tally[REASON_WATCHDOG],
               reason_tally[REASON_BAD_FRAME], reason_tally[REASON_NONFINITE], silent_tally);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
